/* hdl/smx_pkg.sv */
package smx_pkg;

  localparam int unsigned MAX_MESSAGE_BYTES = 67108864;
  localparam int unsigned LenW = 27;
  localparam logic [LenW-1:0] LEN_CAP =
    (MAX_MESSAGE_BYTES < 32'h07FF_FFFF) ? LenW'(MAX_MESSAGE_BYTES) : {LenW{1'b1}};

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);

  localparam logic [7:0] CH_D   = 8'h44;
  localparam logic [7:0] CH_A   = 8'h41;
  localparam logic [7:0] CH_T   = 8'h54;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_DOT = 8'h2E;

  typedef enum logic [1:0] {
    HELD_NONE,
    HELD_DOT,
    HELD_DOT_CR
  } held_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       flow_start;
  } item_t;

  typedef struct packed {
    logic [7:0]      out_byte;
    logic            byte_valid;
    logic            in_body;
    logic            header_end;
    logic            message_end;
    logic [LenW-1:0] message_length;
    logic            last_of_run;
  } result_t;

  // fresh: first descriptor of a message, clears the byte counters first.
  // cnt 1: data; cnt 2: '.', data; cnt 3: '.', CR, data.
  typedef struct packed {
    logic       fresh;
    logic       is_end;
    logic [1:0] cnt;
    logic [7:0] data;
  } desc_t;

  function automatic logic [7:0] cmd_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CH_D;
      3'd1:    c = CH_A;
      3'd2:    c = CH_T;
      3'd3:    c = CH_A;
      3'd4:    c = CH_CR;
      3'd5:    c = CH_LF;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* hdl/smx_front.sv */
module smx_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  smx_pkg::item_t item_i,
  output smx_pkg::desc_t desc_o,
  output logic           desc_valid_o
);
  import smx_pkg::*;

  logic        mode_q, mode_d;
  logic [2:0]  match_q, match_d;
  logic        start_q, start_d;
  logic [15:0] last2_q, last2_d;
  held_e       held_q, held_d;
  logic        fresh_q, fresh_d;

  logic        eff_mode;
  logic [2:0]  eff_match;
  logic        eff_start;
  logic [15:0] eff_last2;
  held_e       eff_held;
  logic        eff_fresh;
  logic [7:0]  b;
  logic        bol;
  logic [2:0]  m;
  logic        hit;
  logic [2:0]  m_next;

  assign b         = item_i.data_byte;
  assign eff_mode  = item_i.flow_start ? 1'b0 : mode_q;
  assign eff_match = item_i.flow_start ? 3'd0 : match_q;
  assign eff_start = item_i.flow_start ? 1'b1 : start_q;
  assign eff_last2 = item_i.flow_start ? 16'h0000 : last2_q;
  assign eff_held  = item_i.flow_start ? HELD_NONE : held_q;
  assign eff_fresh = item_i.flow_start ? 1'b0 : fresh_q;
  assign bol       = eff_start || (eff_last2 == {CH_CR, CH_LF});

  assign m      = (eff_match > 3'd5) ? 3'd0 : eff_match;
  assign hit    = ((m == 3'd0) && bol && (b == CH_D)) ||
                  ((m != 3'd0) && (b == cmd_char(m)));
  assign m_next = hit ? (m + 3'd1) : ((bol && (b == CH_D)) ? 3'd1 : 3'd0);

  // next state
  always_comb begin
    mode_d  = eff_mode;
    match_d = eff_match;
    held_d  = eff_held;
    fresh_d = eff_fresh;
    last2_d = {eff_last2[7:0], b};
    start_d = 1'b0;
    if (!eff_mode) begin
      if (m_next == 3'd6) begin
        mode_d  = 1'b1;
        match_d = 3'd0;
        held_d  = HELD_NONE;
        fresh_d = 1'b1;
      end else begin
        match_d = m_next;
      end
    end else begin
      case (eff_held)
        HELD_NONE: begin
          if (bol && (b == CH_DOT)) begin
            held_d = HELD_DOT;
          end else begin
            fresh_d = 1'b0;
          end
        end
        HELD_DOT: begin
          if (b == CH_CR) begin
            held_d = HELD_DOT_CR;
          end else begin
            held_d  = HELD_NONE;
            fresh_d = 1'b0;
          end
        end
        HELD_DOT_CR: begin
          held_d  = HELD_NONE;
          fresh_d = 1'b0;
          if (b == CH_LF) begin
            mode_d  = 1'b0;
            match_d = 3'd0;
          end
        end
        default: begin
          held_d = HELD_NONE;
        end
      endcase
    end
  end

  // descriptor output
  always_comb begin
    desc_valid_o  = 1'b0;
    desc_o.fresh  = eff_fresh;
    desc_o.is_end = 1'b0;
    desc_o.cnt    = 2'd1;
    desc_o.data   = b;
    if (eff_mode && accept_i) begin
      case (eff_held)
        HELD_NONE: begin
          desc_valid_o = !(bol && (b == CH_DOT));
        end
        HELD_DOT: begin
          desc_valid_o = (b != CH_CR);
          desc_o.cnt   = (b == CH_DOT) ? 2'd1 : 2'd2;
        end
        HELD_DOT_CR: begin
          desc_valid_o  = 1'b1;
          desc_o.is_end = (b == CH_LF);
          desc_o.cnt    = (b == CH_LF) ? 2'd1 : 2'd3;
        end
        default: begin
          desc_valid_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      match_q <= 3'd0;
      start_q <= 1'b1;
      last2_q <= 16'h0000;
      held_q  <= HELD_NONE;
      fresh_q <= 1'b0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      match_q <= match_d;
      start_q <= start_d;
      last2_q <= last2_d;
      held_q  <= held_d;
      fresh_q <= fresh_d;
    end
  end

endmodule

/* hdl/smx_fifo.sv */
module smx_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  smx_pkg::desc_t wdata_i,
  input  logic           pop_i,
  output smx_pkg::desc_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);
  import smx_pkg::*;

  desc_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (QPtrW+1)'(QDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* hdl/smx_back.sv */
module smx_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  smx_pkg::desc_t   head_i,
  input  logic             head_valid_i,
  output logic             head_pop_o,
  input  logic             out_pop_i,
  output smx_pkg::result_t result_o,
  output logic             out_valid_o
);
  import smx_pkg::*;

  logic [1:0]      idx_q;
  logic [1:0]      blank_q, blank_d;
  logic            header_q, header_d;
  logic [LenW-1:0] len_q, len_d;
  result_t         out_q, res_d;
  logic            out_valid_q;

  logic            advance;
  logic            clear;
  logic [1:0]      eff_blank;
  logic            eff_header;
  logic [LenW-1:0] eff_len;
  logic [7:0]      cur_byte;
  logic            last_sub;
  logic [7:0]      want;

  assign advance    = head_valid_i && (!out_valid_q || out_pop_i);
  assign clear      = head_i.fresh && (idx_q == 2'd0);
  assign eff_blank  = clear ? 2'd0 : blank_q;
  assign eff_header = clear ? 1'b0 : header_q;
  assign eff_len    = clear ? '0 : len_q;
  assign last_sub   = head_i.is_end || (idx_q == 2'(head_i.cnt - 2'd1));
  assign head_pop_o = advance && last_sub;
  assign want       = eff_blank[0] ? CH_LF : CH_CR;

  always_comb begin
    case (head_i.cnt)
      2'd3: begin
        cur_byte = (idx_q == 2'd0) ? CH_DOT : ((idx_q == 2'd1) ? CH_CR : head_i.data);
      end
      2'd2: begin
        cur_byte = (idx_q == 2'd0) ? CH_DOT : head_i.data;
      end
      default: begin
        cur_byte = head_i.data;
      end
    endcase
  end

  always_comb begin
    res_d             = '0;
    res_d.last_of_run = last_sub;
    blank_d           = eff_blank;
    header_d          = eff_header;
    len_d             = eff_len;
    if (head_i.is_end) begin
      res_d.message_end    = 1'b1;
      res_d.message_length = eff_len;
      blank_d              = 2'd0;
      header_d             = 1'b0;
      len_d                = '0;
    end else begin
      res_d.out_byte   = cur_byte;
      res_d.byte_valid = 1'b1;
      res_d.in_body    = eff_header;
      if (eff_len < LEN_CAP) begin
        len_d = eff_len + 1'b1;
      end
      if (!eff_header) begin
        if (cur_byte == want) begin
          if (eff_blank == 2'd3) begin
            header_d         = 1'b1;
            res_d.header_end = 1'b1;
            blank_d          = 2'd0;
          end else begin
            blank_d = eff_blank + 2'd1;
          end
        end else begin
          blank_d = (cur_byte == CH_CR) ? 2'd1 : 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      blank_q     <= 2'd0;
      header_q    <= 1'b0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        idx_q       <= last_sub ? 2'd0 : (idx_q + 2'd1);
        blank_q     <= blank_d;
        header_q    <= header_d;
        len_q       <= len_d;
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign result_o    = out_q;
  assign out_valid_o = out_valid_q;

  a_end_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.message_end |-> out_q.last_of_run && !out_q.byte_valid)
    else $error("end beat carries a byte or is not last of run");

  a_mid_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd0 |-> head_valid_i && !head_i.is_end)
    else $error("descriptor left mid-sequence");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd0 |-> idx_q < head_i.cnt)
    else $error("sub-beat index past descriptor count");

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_CAP)
    else $error("length counter above cap");

endmodule

/* hdl/smtp_message_extractor_unit.sv */
// SMTP DATA extractor with leading-dot unstuffing.
// Input queue side: one client stream byte per beat (item_i), accepted when
// push is high and full is low. flow_start in a beat resets the parser to
// command mode before that byte is parsed.
// Result queue side: result_o holds the oldest result while empty is low;
// it is taken when pop is high. Each byte yields zero to three beats: message
// bytes, and one end-only beat per message carrying the saturated length.
// last_of_run marks the final beat of one input byte.
// The first result of a byte passes the descriptor queue and output register.
// Throughput: one byte per cycle while results are drained and full is
// low; result beats leave at one per cycle while pop is high, set by the
// single back-end output register. A 4-entry descriptor queue between the
// parser and the output stage absorbs bytes that expand into 2 or 3 beats;
// full rises when it fills, including while pop is held low.
// Reset: command mode, at stream start, all queues empty.
module smtp_message_extractor_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  smx_pkg::item_t   item_i,
  output logic             empty,
  input  logic             pop,
  output smx_pkg::result_t result_o
);
  import smx_pkg::*;

  desc_t desc, head;
  logic  desc_valid;
  logic  accept;
  logic  q_empty;
  logic  head_pop;
  logic  out_valid;
  logic  out_pop;

  assign accept  = push && !full;
  assign empty   = !out_valid;
  assign out_pop = pop && out_valid;

  smx_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .item_i       (item_i),
    .desc_o       (desc),
    .desc_valid_o (desc_valid)
  );

  smx_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_valid),
    .wdata_i (desc),
    .pop_i   (head_pop),
    .rdata_o (head),
    .full_o  (full),
    .empty_o (q_empty)
  );

  smx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (!q_empty),
    .head_pop_o   (head_pop),
    .out_pop_i    (out_pop),
    .result_o     (result_o),
    .out_valid_o  (out_valid)
  );

endmodule

/* test/smtp_message_extractor_unit_tb.sv */
module smtp_message_extractor_unit_tb;
  import smx_pkg::*;

  localparam int PREDICT = -1;
  localparam int HOLD_CYCLES = 250;
  localparam int IDLE_LIMIT = 2000;
  localparam int ITEM_TARGET = 330;
  localparam logic [7:0] DATA_CMD [6] = '{CH_D, CH_A, CH_T, CH_A, CH_CR, CH_LF};

  localparam result_t NO_BEAT = '0;
  localparam result_t EMPTY_END = '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 27'd0, 1'b1};
  localparam result_t FINAL_END = '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 27'd13, 1'b1};

  typedef struct {
    logic [7:0] b;
    logic       fs;
    int         n;
    result_t    beat;
  } dir_row_t;

  logic    clk_i;
  logic    rst_ni;
  logic    push;
  logic    full;
  logic    empty;
  logic    pop;
  item_t   item_in;
  result_t result_out;

  // typed expectation riding along with the byte on the input side
  int      typed_n;
  result_t typed_beat;

  // shadow parser state
  logic            data_mode;
  logic [2:0]      cmd_idx;
  logic            at_start;
  logic [15:0]     prev_two;
  held_e           held;
  logic [1:0]      blank_prog;
  logic            hdr_seen;
  logic [LenW-1:0] msg_len;

  result_t new_beats[$];
  result_t pending_results[$];
  item_t   stim_q[$];
  logic    next_fs;
  int      msg_planned;

  int fail_count;
  int items_taken;
  int beats_checked;
  int msgs_closed;
  int idle_cycles;
  int beats_taken;
  int tx_calm;
  int rx_calm;
  bit held_off;

  dir_row_t dir_rows [32];

  smtp_message_extractor_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_in),
    .empty   (empty),
    .pop     (pop),
    .result_o(result_out)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) calm = int'($urandom_range(8, 40));
    if ($urandom_range(0, 1) == 1) return int'($urandom_range(0, 2));
    return int'($urandom_range(0, 18));
  endfunction

  function void clear_state();
    data_mode  = 1'b0;
    cmd_idx    = '0;
    at_start   = 1'b1;
    prev_two   = '0;
    held       = HELD_NONE;
    blank_prog = '0;
    hdr_seen   = 1'b0;
    msg_len    = '0;
  endfunction

  function void put_msg_byte(logic [7:0] b);
    result_t    r;
    logic [7:0] want;
    r            = '0;
    r.out_byte   = b;
    r.byte_valid = 1'b1;
    r.in_body    = hdr_seen;
    if (msg_len < LEN_CAP) msg_len = msg_len + 1'b1;
    if (!hdr_seen) begin
      want = blank_prog[0] ? CH_LF : CH_CR;
      if (b == want) begin
        if (blank_prog == 2'd3) begin
          hdr_seen     = 1'b1;
          r.header_end = 1'b1;
          blank_prog   = '0;
        end else begin
          blank_prog = blank_prog + 2'd1;
        end
      end else begin
        blank_prog = (b == CH_CR) ? 2'd1 : 2'd0;
      end
    end
    new_beats.push_back(r);
  endfunction

  function void predict_byte(item_t it);
    logic [7:0] b;
    logic       bol;
    logic [2:0] m;
    result_t    r;
    b = it.data_byte;
    new_beats.delete();
    if (it.flow_start) clear_state();
    bol = at_start || prev_two == {CH_CR, CH_LF};
    if (!data_mode) begin
      m = cmd_idx;
      if (m > 3'd5) m = '0;
      if ((m == 0 && bol && b == CH_D) || (m > 0 && b == DATA_CMD[m])) begin
        m = m + 3'd1;
      end else begin
        m = (bol && b == CH_D) ? 3'd1 : 3'd0;
      end
      if (m == 3'd6) begin
        data_mode  = 1'b1;
        cmd_idx    = '0;
        held       = HELD_NONE;
        blank_prog = '0;
        hdr_seen   = 1'b0;
        msg_len    = '0;
      end else begin
        cmd_idx = m;
      end
    end else begin
      case (held)
        HELD_NONE: begin
          if (bol && b == CH_DOT) held = HELD_DOT;
          else put_msg_byte(b);
        end
        HELD_DOT: begin
          if (b == CH_DOT) begin
            put_msg_byte(CH_DOT);
            held = HELD_NONE;
          end else if (b == CH_CR) begin
            held = HELD_DOT_CR;
          end else begin
            put_msg_byte(CH_DOT);
            put_msg_byte(b);
            held = HELD_NONE;
          end
        end
        HELD_DOT_CR: begin
          if (b == CH_LF) begin
            r                = '0;
            r.message_end    = 1'b1;
            r.message_length = msg_len;
            new_beats.push_back(r);
            data_mode  = 1'b0;
            cmd_idx    = '0;
            held       = HELD_NONE;
            blank_prog = '0;
            hdr_seen   = 1'b0;
            msg_len    = '0;
          end else begin
            put_msg_byte(CH_DOT);
            put_msg_byte(CH_CR);
            put_msg_byte(b);
            held = HELD_NONE;
          end
        end
        default: begin
          held = HELD_NONE;
        end
      endcase
    end
    prev_two = {prev_two[7:0], b};
    at_start = 1'b0;
    if (new_beats.size() > 0) new_beats[new_beats.size()-1].last_of_run = 1'b1;
  endfunction

  function void add_byte(logic [7:0] b);
    item_t it;
    it.data_byte  = b;
    it.flow_start = next_fs || ($urandom_range(0, 299) == 0);
    next_fs = 1'b0;
    stim_q.push_back(it);
  endfunction

  function logic [7:0] msg_char();
    case ($urandom_range(0, 7))
      0:       return CH_CR;
      1:       return CH_LF;
      2:       return CH_DOT;
      default: return 8'($urandom);
    endcase
  endfunction

  // command chatter, DATA line, dot-stuffed message, terminator (or abandon)
  function void gen_session();
    int         start;
    logic [7:0] c;
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0: begin
          for (int k = 0; k < 3; k++) add_byte(DATA_CMD[k]);
          add_byte(8'($urandom));
        end
        1: begin
          for (int k = 0; k < 4; k++) add_byte(DATA_CMD[k]);
          add_byte(8'($urandom));
        end
        default: repeat ($urandom_range(1, 5)) add_byte(8'($urandom));
      endcase
      add_byte(CH_CR);
      add_byte(CH_LF);
    end
    for (int k = 0; k < 6; k++) add_byte(DATA_CMD[k]);
    start = stim_q.size();
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 5))
        0: add_byte(CH_DOT);
        1: begin
          add_byte(CH_DOT);
          add_byte(CH_DOT);
        end
        2: begin
          add_byte(CH_DOT);
          add_byte(CH_CR);
          c = msg_char();
          if (c == CH_LF) c = CH_DOT;
          add_byte(c);
        end
        default: ;
      endcase
      repeat ($urandom_range(0, 6)) add_byte(msg_char());
      add_byte(CH_CR);
      add_byte(CH_LF);
    end
    msg_planned += stim_q.size() - start;
    if ($urandom_range(0, 9) == 0) begin
      next_fs = 1'b1;
    end else begin
      add_byte(CH_DOT);
      add_byte(CH_CR);
      add_byte(CH_LF);
    end
  endfunction

  task automatic send_beat(item_t it, int tn, result_t tb);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push       <= 1'b1;
    item_in    <= it;
    typed_n    <= tn;
    typed_beat <= tb;
    do @(posedge clk_i); while (full);
  endtask

  task automatic check_beat(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected beat: out_byte %0h message_end %0b", got.out_byte, got.message_end);
      fail_count++;
    end else begin
      want = pending_results.pop_front();
      beats_checked++;
      if (got.message_end) msgs_closed++;
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
        fail_count++;
      end
      if (got.byte_valid !== want.byte_valid) begin
        $error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
        fail_count++;
      end
      if (got.in_body !== want.in_body) begin
        $error("in_body: expected %0b, got %0b", want.in_body, got.in_body);
        fail_count++;
      end
      if (got.header_end !== want.header_end) begin
        $error("header_end: expected %0b, got %0b", want.header_end, got.header_end);
        fail_count++;
      end
      if (got.message_end !== want.message_end) begin
        $error("message_end: expected %0b, got %0b", want.message_end, got.message_end);
        fail_count++;
      end
      if (got.message_length !== want.message_length) begin
        $error("message_length: expected %0d, got %0d", want.message_length,
               got.message_length);
        fail_count++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        predict_byte(item_in);
        if (typed_n == PREDICT) begin
          foreach (new_beats[i]) pending_results.push_back(new_beats[i]);
        end else if (typed_n == 1) begin
          pending_results.push_back(typed_beat);
        end
        items_taken++;
      end
      if (pop && !empty) check_beat(result_out);
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: %0d cycles without a beat", idle_cycles);
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  // result side
  initial begin
    int wait_n;
    pop = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (beats_taken == 40 && !held_off) begin
        held_off = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        wait_n = draw_gap(rx_calm);
        if (wait_n > 0) begin
          pop <= 1'b0;
          repeat (wait_n) @(posedge clk_i);
        end
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      beats_taken++;
    end
  end

  // byte side
  initial begin
    item_t it;
    rst_ni     = 1'b0;
    push       = 1'b0;
    item_in    = '0;
    typed_n    = PREDICT;
    typed_beat = '0;
    next_fs    = 1'b0;
    clear_state();

    // empty message, flow restart, message opening with CR LF, dot cases
    dir_rows = '{
      '{CH_D,   1'b1, 0,       NO_BEAT},
      '{CH_A,   1'b0, 0,       NO_BEAT},
      '{CH_T,   1'b0, 0,       NO_BEAT},
      '{CH_A,   1'b0, 0,       NO_BEAT},
      '{CH_CR,  1'b0, 0,       NO_BEAT},
      '{CH_LF,  1'b0, 0,       NO_BEAT},
      '{CH_DOT, 1'b0, 0,       NO_BEAT},
      '{CH_CR,  1'b0, 0,       NO_BEAT},
      '{CH_LF,  1'b0, 1,       EMPTY_END},
      '{CH_D,   1'b1, 0,       NO_BEAT},
      '{CH_A,   1'b0, 0,       NO_BEAT},
      '{CH_T,   1'b0, 0,       NO_BEAT},
      '{CH_A,   1'b0, 0,       NO_BEAT},
      '{CH_CR,  1'b0, 0,       NO_BEAT},
      '{CH_LF,  1'b0, 0,       NO_BEAT},
      '{CH_CR,  1'b0, PREDICT, NO_BEAT},
      '{CH_LF,  1'b0, PREDICT, NO_BEAT},
      '{CH_DOT, 1'b0, 0,       NO_BEAT},
      '{CH_DOT, 1'b0, PREDICT, NO_BEAT},
      '{CH_CR,  1'b0, PREDICT, NO_BEAT},
      '{CH_LF,  1'b0, PREDICT, NO_BEAT},
      '{CH_CR,  1'b0, PREDICT, NO_BEAT},
      '{CH_LF,  1'b0, PREDICT, NO_BEAT},
      '{CH_DOT, 1'b0, 0,       NO_BEAT},
      '{CH_CR,  1'b0, 0,       NO_BEAT},
      '{8'hFF,  1'b0, PREDICT, NO_BEAT},
      '{8'h00,  1'b0, PREDICT, NO_BEAT},
      '{CH_CR,  1'b0, PREDICT, NO_BEAT},
      '{CH_LF,  1'b0, PREDICT, NO_BEAT},
      '{CH_DOT, 1'b0, 0,       NO_BEAT},
      '{CH_CR,  1'b0, 0,       NO_BEAT},
      '{CH_LF,  1'b0, 1,       FINAL_END}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      it.data_byte  = dir_rows[i].b;
      it.flow_start = dir_rows[i].fs;
      send_beat(it, dir_rows[i].n, dir_rows[i].beat);
    end

    // drain before the random sessions
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);

    while (stim_q.size() + $size(dir_rows) < ITEM_TARGET) gen_session();
    foreach (stim_q[i]) send_beat(stim_q[i], PREDICT, NO_BEAT);

    push <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d stream bytes fed (%0d planned message bytes), %0d beats checked, %0d messages closed",
             items_taken, msg_planned, beats_checked, msgs_closed);
    $display("long pop stall %0s, %0d field mismatches",
             held_off ? "exercised" : "not reached", fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* smtp_message_extractor_unit.f */
hdl/smx_pkg.sv
hdl/smx_front.sv
hdl/smx_fifo.sv
hdl/smx_back.sv
hdl/smtp_message_extractor_unit.sv
test/smtp_message_extractor_unit_tb.sv
